/* hdl/assert_macros.svh */
// assertion macros shared by the receiver rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define DSFR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DSFR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/dsfr_pkg.sv */
// shared types and constants for the dle/stx frame receiver
package dsfr_pkg;

   localparam logic [7:0]  CHAR_DLE     = 8'h10;
   localparam logic [7:0]  CHAR_STX     = 8'h02;
   localparam logic [7:0]  CHAR_ETX     = 8'h03;
   localparam logic [7:0]  CHAR_ESC     = 8'h1B;
   localparam logic [15:0] LEN_OVERHEAD = 16'd4;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 64;

   typedef enum logic [1:0] {
      KIND_DATA  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ABORT = 2'd2,
      KIND_DIAG  = 2'd3
   } dsfr_kind_type;

   typedef enum logic [7:0] {
      PH_IDLE = 8'b0000_0001,
      PH_STX  = 8'b0000_0010,
      PH_LEN  = 8'b0000_0100,
      PH_FUNC = 8'b0000_1000,
      PH_DATA = 8'b0001_0000,
      PH_CHK  = 8'b0010_0000,
      PH_TDLE = 8'b0100_0000,
      PH_ETX  = 8'b1000_0000
   } dsfr_phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       echo_req;
   } dsfr_item_type;

   typedef struct packed {
      dsfr_kind_type kind;
      logic [7:0]    data_byte;
      logic [15:0]   byte_index;
      logic [15:0]   function_code;
      logic [15:0]   data_count;
      logic          checksum_ok;
      logic          echo_out;
   } dsfr_result_type;

endpackage

/* hdl/dle_stx_frame_receiver.sv */
// top level of the dle/stx framed serial receiver with xor checksum
// a request is captured in the input register and its result, if any, in the result register
// throughput: one request per cycle while the response stream is not stalled; the input and
// result registers each hold one entry and the parser state advances once per byte in a single combinational pass
// reset: synchronous, active high; clears the valid flags of both registers, the parser to
// wait-for-dle, diagnostic mode off and the powered-up register to 0; no clearing pass
`include "assert_macros.svh"

module dle_stx_frame_receiver
   import dsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: rx_byte [7:0], echo_req [8], zero [15:9]
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: data_byte [7:0], byte_index [23:8], function_code [39:24],
   //            data_count [55:40], checksum_ok [56], echo_out [57], zero [63:58]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // rsp_tuser: kind [1:0]
   output logic [1:0]            rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_wdata
);

   logic            item_valid;
   dsfr_item_type   item;
   logic            advance;
   logic            res_valid;
   dsfr_result_type res;
   logic            diag_active;

   assign csr_ready = 1'b1;

   // a byte moves on when the result register is free or being emptied
   assign advance = item_valid && (!rsp_tvalid || rsp_tready);

   dsfr_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   dsfr_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata),
      .step        (advance),
      .item        (item),
      .res_valid   (res_valid),
      .res         (res),
      .diag_active (diag_active)
   );

   dsfr_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .res_valid  (res_valid),
      .res        (res),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   `DSFR_ASSERT_NOW(a_no_advance_on_stall, clock, reset, rsp_tvalid && !rsp_tready, !advance, "parser advanced while result stalled")
   `DSFR_ASSERT_NEXT(a_diag_sticky, clock, reset, diag_active, diag_active, "diagnostic mode left without reset")
   `DSFR_ASSERT_NOW(a_diag_kind, clock, reset, rsp_tvalid && rsp_tuser == KIND_DIAG, diag_active, "diagnostic result outside diagnostic mode")
   `DSFR_ASSERT_NOW(a_ready_when_empty, clock, reset, !item_valid, req_tready, "input register empty but request refused")

endmodule

/* hdl/dsfr_in_stage.sv */
// input register holding one received byte ahead of the parser
module dsfr_in_stage
   import dsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  take,
   output logic                  item_valid,
   output dsfr_item_type         item
);

   logic          valid_ff, valid_in;
   dsfr_item_type item_ff, item_in;
   logic          accept;

   assign req_tready = !valid_ff || take;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      item_in          = item_ff;
      valid_in         = valid_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (accept) begin
         valid_in         = 1'b1;
         item_in.rx_byte  = req_tdata[7:0];
         item_in.echo_req = req_tdata[8];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* hdl/dsfr_parser.sv */
// frame parser state and per-byte result logic
module dsfr_parser
   import dsfr_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   input  logic            csr_wdata,
   input  logic            step,
   input  dsfr_item_type   item,
   output logic            res_valid,
   output dsfr_result_type res,
   output logic            diag_active
);

   dsfr_phase_type phase_ff, phase_in;
   logic [7:0]     latch_ff, latch_in;
   logic           hstep_ff, hstep_in;
   logic [15:0]    expected_ff, expected_in;
   logic [15:0]    received_ff, received_in;
   logic [15:0]    function_ff, function_in;
   logic [7:0]     chksum_ff, chksum_in;
   logic           matched_ff, matched_in;
   logic           diag_ff, diag_in;
   logic           powered_ff, powered_in;

   logic [7:0]     b;
   logic [15:0]    word;
   logic [15:0]    count_inc;

   assign b         = item.rx_byte;
   assign word      = {latch_ff, b};
   assign count_inc = received_ff + 16'd1;

   assign powered_in = csr_valid ? csr_wdata : powered_ff;

   always_comb begin
      phase_in    = phase_ff;
      latch_in    = latch_ff;
      hstep_in    = hstep_ff;
      expected_in = expected_ff;
      received_in = received_ff;
      function_in = function_ff;
      chksum_in   = chksum_ff;
      matched_in  = matched_ff;
      diag_in     = diag_ff;

      res_valid         = 1'b0;
      res.kind          = KIND_DATA;
      res.data_byte     = '0;
      res.byte_index    = '0;
      res.function_code = '0;
      res.data_count    = '0;
      res.checksum_ok   = 1'b0;
      res.echo_out      = 1'b0;

      if (step) begin
         if (diag_ff) begin
            res_valid     = 1'b1;
            res.kind      = KIND_DIAG;
            res.data_byte = b;
            res.echo_out  = item.echo_req;
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  if (b == CHAR_DLE) begin
                     phase_in = PH_STX;
                  end else if (!powered_ff && b == CHAR_ESC) begin
                     diag_in = 1'b1;
                  end
               end
               PH_STX: begin
                  if (b == CHAR_STX) begin
                     phase_in    = PH_LEN;
                     hstep_in    = 1'b0;
                     received_in = '0;
                     chksum_in   = '0;
                  end else begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_LEN, PH_FUNC: begin
                  chksum_in = chksum_ff ^ b;
                  if (!hstep_ff) begin
                     latch_in = b;
                     hstep_in = 1'b1;
                  end else begin
                     hstep_in = 1'b0;
                     if (phase_ff == PH_LEN) begin
                        // short lengths give an empty payload
                        expected_in = (word >= LEN_OVERHEAD) ? word - LEN_OVERHEAD : '0;
                        phase_in    = PH_FUNC;
                     end else begin
                        function_in = word;
                        received_in = '0;
                        phase_in    = (expected_ff != '0) ? PH_DATA : PH_CHK;
                     end
                  end
               end
               PH_DATA: begin
                  chksum_in      = chksum_ff ^ b;
                  res_valid      = 1'b1;
                  res.data_byte  = b;
                  res.byte_index = received_ff;
                  received_in    = count_inc;
                  if (count_inc >= expected_ff) begin
                     phase_in = PH_CHK;
                  end
               end
               PH_CHK: begin
                  matched_in = (b == chksum_ff);
                  phase_in   = PH_TDLE;
               end
               PH_TDLE: begin
                  if (b == CHAR_DLE) begin
                     phase_in = PH_ETX;
                  end else begin
                     res_valid         = 1'b1;
                     res.kind          = KIND_ABORT;
                     res.function_code = function_ff;
                     res.data_count    = expected_ff;
                     res.checksum_ok   = matched_ff;
                     phase_in          = PH_IDLE;
                  end
               end
               PH_ETX: begin
                  res_valid         = 1'b1;
                  res.kind          = (b == CHAR_ETX) ? KIND_DONE : KIND_ABORT;
                  res.function_code = function_ff;
                  res.data_count    = expected_ff;
                  res.checksum_ok   = matched_ff;
                  phase_in          = PH_IDLE;
                  received_in       = '0;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         latch_ff    <= '0;
         hstep_ff    <= 1'b0;
         expected_ff <= '0;
         received_ff <= '0;
         function_ff <= '0;
         chksum_ff   <= '0;
         matched_ff  <= 1'b0;
         diag_ff     <= 1'b0;
         powered_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         latch_ff    <= latch_in;
         hstep_ff    <= hstep_in;
         expected_ff <= expected_in;
         received_ff <= received_in;
         function_ff <= function_in;
         chksum_ff   <= chksum_in;
         matched_ff  <= matched_in;
         diag_ff     <= diag_in;
         powered_ff  <= powered_in;
      end
   end

   assign diag_active = diag_ff;

endmodule

/* hdl/dsfr_out_stage.sv */
// result register driving the response stream
module dsfr_out_stage
   import dsfr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic                  res_valid,
   input  dsfr_result_type       res,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser
);

   logic            valid_ff, valid_in;
   dsfr_result_type res_ff, res_in;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = res_valid;
         res_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.kind;
   assign rsp_tdata  = {6'b0, res_ff.echo_out, res_ff.checksum_ok, res_ff.data_count,
                        res_ff.function_code, res_ff.byte_index, res_ff.data_byte};

endmodule
